// ----- sv/pgh_pkg.sv -----
package pgh_pkg;

  localparam int COORD_W = 16;
  localparam int RIDX_W  = 12;
  localparam int VAL_W   = 16;
  localparam int RANGE_W = 15;
  // Wide enough for grids of up to 181 x 181 cells.
  localparam int CIDX_W  = 15;

  localparam logic [RANGE_W-1:0] RANGE_RESET  = 15'd5000;
  localparam logic [VAL_W-1:0]   COUNT_MAX    = 16'hFFFF;
  localparam logic [VAL_W-1:0]   MARK_VEHICLE = 16'd999;
  localparam logic [VAL_W-1:0]   MARK_ORIGIN  = 16'd9999;

  typedef enum logic [1:0] {
    REQ_POINT = 2'd0,
    REQ_MARK  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_kind_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    req_kind_t         kind;
    logic [CIDX_W-1:0] index;
    logic              in_range;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_push_t;

endpackage

// ----- sv/pgh_front.sv -----
module pgh_front import pgh_pkg::*; #(
  parameter int GRID_HALF = 25
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      block_busy,
  input  logic [1:0]                req_type,
  input  logic signed [COORD_W-1:0] x_pos,
  input  logic signed [COORD_W-1:0] y_pos,
  input  logic [RIDX_W-1:0]         read_index,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [RANGE_W-1:0]        cfg_data,
  input  logic                      q_full,
  output cmd_push_t                 q_in,
  output logic                      front_busy
);

  localparam int STRIDE = 2 * GRID_HALF + 1;
  localparam int CELLS  = STRIDE * STRIDE;
  localparam int QB     = $clog2(GRID_HALF + 1);
  localparam int DIV_W  = COORD_W + QB + 1;
  localparam int OFF_W  = $clog2(STRIDE);
  localparam int CNT_W  = $clog2(QB + 1);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_LOAD = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t       st;
  logic [RANGE_W-1:0] scan_range;
  req_kind_t          kind;
  logic [COORD_W-1:0] mag_x, mag_y;
  logic               neg_x, neg_y;
  logic [RIDX_W-1:0]  rd_idx;
  logic [DIV_W-1:0]   rem_x, rem_y, dsh;
  logic [QB:0]        q_x, q_y;
  logic [CNT_W-1:0]   cnt;

  logic [RANGE_W-1:0] r_eff;
  logic               ge_x, ge_y;
  logic [QB-1:0]      qc_x, qc_y;
  logic [OFF_W-1:0]   col, row;
  logic [CIDX_W-1:0]  cell_idx;
  logic               accept;

  assign accept     = start && !block_busy;
  assign front_busy = (st != F_IDLE);
  assign cfg_ready  = (st == F_IDLE);
  assign r_eff      = (scan_range == '0) ? RANGE_W'(1) : scan_range;
  assign ge_x       = (rem_x >= dsh);
  assign ge_y       = (rem_y >= dsh);

  // A set top quotient bit means the quotient is at least 2^QB, past the edge.
  assign qc_x = (q_x[QB] || (q_x[QB-1:0] > QB'(GRID_HALF))) ? QB'(GRID_HALF) : q_x[QB-1:0];
  assign qc_y = (q_y[QB] || (q_y[QB-1:0] > QB'(GRID_HALF))) ? QB'(GRID_HALF) : q_y[QB-1:0];

  assign col = neg_x ? OFF_W'(GRID_HALF) - OFF_W'(qc_x) : OFF_W'(GRID_HALF) + OFF_W'(qc_x);
  assign row = neg_y ? OFF_W'(GRID_HALF) - OFF_W'(qc_y) : OFF_W'(GRID_HALF) + OFF_W'(qc_y);
  assign cell_idx = CIDX_W'(row) * CIDX_W'(STRIDE) + CIDX_W'(col);

  always_comb begin
    q_in.push         = (st == F_PUSH) && !q_full;
    q_in.cmd.kind     = kind;
    q_in.cmd.index    = cell_idx;
    q_in.cmd.in_range = 1'b1;
    if (kind inside {REQ_READ, REQ_CLEAR}) begin
      q_in.cmd.index    = CIDX_W'(rd_idx);
      q_in.cmd.in_range = (CIDX_W'(rd_idx) < CIDX_W'(CELLS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= F_IDLE;
      scan_range <= RANGE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scan_range <= cfg_data;
      end
      case (st)
        F_IDLE: begin
          if (accept) begin
            if (req_kind_t'(req_type) inside {REQ_POINT, REQ_MARK}) begin
              st <= F_LOAD;
            end else begin
              st <= F_PUSH;
            end
          end
        end
        F_LOAD: st <= F_DIV;
        F_DIV: begin
          if (cnt == '0) begin
            st <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            st <= F_IDLE;
          end
        end
        default: st <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      F_IDLE: begin
        kind   <= req_kind_t'(req_type);
        neg_x  <= x_pos[COORD_W-1];
        neg_y  <= y_pos[COORD_W-1];
        mag_x  <= x_pos[COORD_W-1] ? COORD_W'(-x_pos) : COORD_W'(x_pos);
        mag_y  <= y_pos[COORD_W-1] ? COORD_W'(-y_pos) : COORD_W'(y_pos);
        rd_idx <= read_index;
      end
      F_LOAD: begin
        // Rounded quotient: (2*|c|*GRID_HALF + r) / (2*r).
        rem_x <= DIV_W'(mag_x) * DIV_W'(2 * GRID_HALF) + DIV_W'(r_eff);
        rem_y <= DIV_W'(mag_y) * DIV_W'(2 * GRID_HALF) + DIV_W'(r_eff);
        dsh   <= DIV_W'({r_eff, 1'b0}) << QB;
        q_x   <= '0;
        q_y   <= '0;
        cnt   <= CNT_W'(QB);
      end
      F_DIV: begin
        if (ge_x) begin
          rem_x <= rem_x - dsh;
        end
        if (ge_y) begin
          rem_y <= rem_y - dsh;
        end
        q_x <= {q_x[QB-1:0], ge_x};
        q_y <= {q_y[QB-1:0], ge_y};
        dsh <= dsh >> 1;
        cnt <= cnt - CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/pgh_cmd_queue.sv -----
module pgh_cmd_queue import pgh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_push_t q_in,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output cmd_t      head
);

  cmd_t       slots [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign head    = slots[rp];
  assign do_push = q_in.push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= q_in.cmd;
    end
  end

endmodule

// ----- sv/pgh_back.sv -----
module pgh_back import pgh_pkg::*; #(
  parameter int GRID_HALF = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  cmd_t              head,
  output logic              pop,
  output logic              clearing,
  output logic              result_valid,
  output logic [RIDX_W-1:0] cell_index,
  output logic [VAL_W-1:0]  cell_value,
  output logic              last_result
);

  localparam int STRIDE = 2 * GRID_HALF + 1;
  localparam int CELLS  = STRIDE * STRIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int ORIGIN = GRID_HALF * STRIDE + GRID_HALF;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_UPD   = 4'b0010,
    B_MARK2 = 4'b0100,
    B_CLR   = 4'b1000
  } back_state_t;

  back_state_t       st;
  cmd_t              cur;
  logic [CELL_W-1:0] clr_cnt;
  logic              clr_ack;
  logic [VAL_W-1:0]  grid_counts [CELLS];
  logic [VAL_W-1:0]  rd_data;
  logic [VAL_W-1:0]  bumped;

  logic              mem_we;
  logic [CELL_W-1:0] mem_wa;
  logic [VAL_W-1:0]  mem_wd;

  assign pop      = (st == B_IDLE) && !q_empty;
  assign clearing = (st == B_CLR);
  assign bumped   = (rd_data == COUNT_MAX) ? rd_data : rd_data + VAL_W'(1);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur.index[CELL_W-1:0];
    mem_wd = bumped;
    case (st)
      B_UPD: begin
        if (cur.kind == REQ_POINT) begin
          mem_we = 1'b1;
        end else if (cur.kind == REQ_MARK) begin
          mem_we = 1'b1;
          mem_wd = MARK_VEHICLE;
        end
      end
      B_MARK2: begin
        mem_we = 1'b1;
        mem_wa = CELL_W'(ORIGIN);
        mem_wd = MARK_ORIGIN;
      end
      B_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
        mem_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_counts[mem_wa] <= mem_wd;
    end
    rd_data <= grid_counts[head.index[CELL_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= B_CLR;
      clr_cnt      <= '0;
      clr_ack      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (st)
        B_IDLE: begin
          if (!q_empty) begin
            if (head.kind == REQ_CLEAR) begin
              st      <= B_CLR;
              clr_cnt <= '0;
              clr_ack <= 1'b1;
            end else begin
              st <= B_UPD;
            end
          end
        end
        B_UPD: begin
          result_valid <= 1'b1;
          st <= (cur.kind == REQ_MARK) ? B_MARK2 : B_IDLE;
        end
        B_MARK2: begin
          result_valid <= 1'b1;
          st <= B_IDLE;
        end
        B_CLR: begin
          clr_cnt <= clr_cnt + CELL_W'(1);
          if (clr_cnt == CELL_W'(CELLS - 1)) begin
            st           <= B_IDLE;
            result_valid <= clr_ack;
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    case (st)
      B_UPD: begin
        cell_index  <= cur.index[RIDX_W-1:0];
        last_result <= (cur.kind != REQ_MARK);
        case (cur.kind)
          REQ_POINT: cell_value <= bumped;
          REQ_MARK:  cell_value <= MARK_VEHICLE;
          default:   cell_value <= cur.in_range ? rd_data : '0;
        endcase
      end
      B_MARK2: begin
        cell_index  <= RIDX_W'(ORIGIN);
        cell_value  <= MARK_ORIGIN;
        last_result <= 1'b1;
      end
      B_CLR: begin
        cell_index  <= '0;
        cell_value  <= '0;
        last_result <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/point_grid_histogram_unit.sv -----
// Point grid histogram: scan points are binned into a square grid of
// (2*GRID_HALF+1) x (2*GRID_HALF+1) saturating 16-bit cell counters, stored
// row major. A request is taken when start is high and busy is low; every
// result appears for exactly one cycle with result_valid high and must be
// captured then, as the block has no way to hold a result back. A point or
// mark request passes through the front end in steps whose length depends on
// GRID_HALF: the inputs are captured, the dividend is formed, the shared
// bit-serial divider runs for x and y together, and the command is handed
// on, waiting while the queue is full. Read and clear requests skip the
// divider and are handed on directly. Behind a two-entry command queue the
// memory end handles a point or read as a registered read, then write and
// result, a mark as two beats, the vehicle cell then the origin cell, in
// adjacent cycles, and a clear one cell per cycle, answering with one beat
// once the whole grid is zero. After reset the grid is swept to zero, which
// holds busy high until the sweep is done; the range register may still be
// written during that sweep.
module point_grid_histogram_unit import pgh_pkg::*; #(
  parameter int GRID_HALF = 25
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                req_type,
  input  logic signed [COORD_W-1:0] x_pos,
  input  logic signed [COORD_W-1:0] y_pos,
  input  logic [RIDX_W-1:0]         read_index,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [RANGE_W-1:0]        cfg_data,
  output logic                      result_valid,
  output logic [RIDX_W-1:0]         cell_index,
  output logic [VAL_W-1:0]          cell_value,
  output logic                      last_result
);

  cmd_push_t q_in;
  cmd_t      head;
  logic      q_full, q_empty, pop;
  logic      front_busy, clearing;

  // No new request is taken while the grid is being swept to zero.
  assign busy = front_busy || clearing;

  pgh_front #(
    .GRID_HALF (GRID_HALF)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .block_busy (busy),
    .req_type   (req_type),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .read_index (read_index),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_in       (q_in),
    .front_busy (front_busy)
  );

  pgh_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .q_in  (q_in),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .head  (head)
  );

  pgh_back #(
    .GRID_HALF (GRID_HALF)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .cell_index   (cell_index),
    .cell_value   (cell_value),
    .last_result  (last_result)
  );

endmodule

// ----- sv/pgh_checker.sv -----
module pgh_checker import pgh_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input logic [VAL_W-1:0] cell_value,
  input logic             last_result
);

  // The grid sweep after reset keeps new requests out.
  a_reset_sweep: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without raising busy");

  // Only a mark gives a non-final beat, and it carries the vehicle value.
  a_first_mark: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |-> (cell_value == MARK_VEHICLE))
    else $error("non-final beat without vehicle mark value");

  a_mark_pair: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |=>
      (result_valid && last_result && (cell_value == MARK_ORIGIN)))
    else $error("vehicle mark not followed by origin mark");

endmodule

bind point_grid_histogram_unit pgh_checker u_pgh_checker (.*);
